// File: sv/rdmw_pkg.sv
// Shared types and constants of the maze walker.
package rdmw_pkg;

	localparam int MAP_DEPTH = 1024;
	localparam int CELL_W = 10;
	localparam int CNT_W = 11;
	localparam int GRID_WIDTH_DEF = 32;
	localparam int GRID_HEIGHT_DEF = 32;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	localparam logic [1:0] DIR_UP = 2'd0;
	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT = 2'd3;

	localparam logic REG_START = 1'b0;
	localparam logic REG_GOAL = 1'b1;

	typedef struct packed {
		cmd_t              cmd;
		logic [CELL_W-1:0] cell_index;
		logic              cell_open;
		logic [1:0]        direction;
	} req_t;

	typedef struct packed {
		logic [CELL_W-1:0] position;
		logic              moved;
		logic              backtracked;
		logic              at_goal;
		logic              no_path;
		logic              cell_used;
		logic              cell_travelled;
	} rsp_t;

	typedef struct packed {
		logic [CELL_W-1:0] addr;
		logic              open_we;
		logic              open_wd;
		logic              used_we;
		logic              used_wd;
		logic              trav_we;
		logic              trav_wd;
	} cell_wr_t;

	typedef struct packed {
		logic open;
		logic used;
		logic trav;
	} cell_bits_t;

endpackage

// File: sv/random_dfs_maze_walker.sv
// Top level of the maze walker: command sequencer, walk state and result register.
// The walker takes one command beat at a time and returns one result beat for it.
// A blocked step or a step that backtracks takes longer than a step that moves, because
// the cell memory serves one neighbour read per cycle. A begin clears the used and
// travelled marks with a sweep over all 1024 cells, one cell per cycle; the same sweep
// runs after reset, and no command beat is taken until it ends. Register writes are
// taken at any time. A finished result waits in an output register, and the next
// command beat is taken while it waits.
module random_dfs_maze_walker import rdmw_pkg::*; #(
	parameter int GRID_WIDTH = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CELL_W-1:0] cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp
);

	localparam int COL_W = $clog2(GRID_WIDTH);
	localparam int SK_W = CELL_W + COL_W;
	localparam int CELL_LIMIT = (GRID_WIDTH * GRID_HEIGHT < MAP_DEPTH) ?
		GRID_WIDTH * GRID_HEIGHT : MAP_DEPTH;
	localparam logic [CELL_W:0] GW = (CELL_W+1)'(GRID_WIDTH);
	localparam logic [CELL_W:0] GLIM = (CELL_W+1)'(CELL_LIMIT);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_WIDTH - 1);

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_CLEAR     = 9'b000000010,
		S_BEGIN_SET = 9'b000000100,
		S_STEP_CHK  = 9'b000001000,
		S_SCAN      = 9'b000010000,
		S_MOVE      = 9'b000100000,
		S_POP       = 9'b001000000,
		S_POP_RD    = 9'b010000000,
		S_RESP      = 9'b100000000
	} state_t;

	typedef struct packed {
		logic              inb;
		logic [CELL_W-1:0] addr;
		logic [COL_W-1:0]  col;
	} nbr_t;

	function automatic nbr_t nbr_of(input logic [CELL_W-1:0] cur,
			input logic [COL_W-1:0] col, input logic [1:0] dir);
		logic [CELL_W:0]  c;
		logic [CELL_W:0]  n;
		logic             ok;
		logic [COL_W-1:0] nc;
		nbr_t             r;
		c = {1'b0, cur};
		n = c;
		ok = 1'b1;
		nc = col;
		unique case (dir)
			DIR_UP: begin
				ok = c >= GW;
				n = c - GW;
			end
			DIR_DOWN: begin
				n = c + GW;
			end
			DIR_RIGHT: begin
				ok = col != COL_LAST;
				n = c + 1'b1;
				nc = col + 1'b1;
			end
			DIR_LEFT: begin
				ok = col != '0;
				n = c - 1'b1;
				nc = col - 1'b1;
			end
		endcase
		r.inb = ok && (n < GLIM);
		r.addr = n[CELL_W-1:0];
		r.col = nc;
		return r;
	endfunction

	state_t            state_q, state_d;
	logic [CELL_W-1:0] clr_q, clr_d;
	logic              clr_init_q, clr_init_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CELL_W-1:0] walker_q, walker_d;
	logic              goal_flag_q, goal_flag_d;
	logic              stuck_q, stuck_d;
	logic              rsp_valid_q, rsp_valid_d;
	logic [CELL_W-1:0] start_q;
	logic [CELL_W-1:0] goal_q;

	logic [COL_W-1:0]  col_q, col_d;
	logic [CELL_W-1:0] rem_q, rem_d;
	nbr_t              nb_q, nb_d;
	logic              inb_s1, inb_d;
	logic [2:0]        scan_q, scan_d;
	logic              free_any_q, free_any_d;
	logic              moved_q, moved_d;
	logic              back_q, back_d;
	logic              qry_q, qry_d;
	rsp_t              rsp_q, rsp_d;

	cell_wr_t          cm_wr;
	logic              cm_re;
	logic [CELL_W-1:0] cm_raddr;
	cell_bits_t        cm_rd;
	logic              sk_we;
	logic [CELL_W-1:0] sk_waddr;
	logic [SK_W-1:0]   sk_wd;
	logic              sk_re;
	logic [CELL_W-1:0] sk_raddr;
	logic [SK_W-1:0]   sk_rd;

	nbr_t              nb_acc;
	nbr_t              nb_scan;
	logic              free_now;

	rdmw_cell_mem u_cell_mem (
		.clk   (clk),
		.wr    (cm_wr),
		.re    (cm_re),
		.raddr (cm_raddr),
		.rd    (cm_rd)
	);

	rdmw_stack_mem #(
		.DATA_W (SK_W)
	) u_stack_mem (
		.clk   (clk),
		.we    (sk_we),
		.waddr (sk_waddr),
		.wd    (sk_wd),
		.re    (sk_re),
		.raddr (sk_raddr),
		.rd    (sk_rd)
	);

	assign nb_acc = nbr_of(walker_q, col_q, req.direction);
	assign nb_scan = nbr_of(walker_q, col_q, scan_q[1:0]);
	assign free_now = inb_s1 & cm_rd.open & ~cm_rd.used;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		clr_init_d = clr_init_q;
		count_d = count_q;
		walker_d = walker_q;
		goal_flag_d = goal_flag_q;
		stuck_d = stuck_q;
		rsp_valid_d = rsp_valid_q & ~rsp_ready;
		col_d = col_q;
		rem_d = rem_q;
		nb_d = nb_q;
		inb_d = inb_s1;
		scan_d = scan_q;
		free_any_d = free_any_q;
		moved_d = moved_q;
		back_d = back_q;
		qry_d = qry_q;
		rsp_d = rsp_q;
		cm_wr = '0;
		cm_re = 1'b0;
		cm_raddr = req.cell_index;
		sk_we = 1'b0;
		sk_waddr = count_q[CELL_W-1:0];
		sk_wd = {nb_q.addr, nb_q.col};
		sk_re = 1'b0;
		sk_raddr = CELL_W'(count_q - CNT_W'(2));

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					moved_d = 1'b0;
					back_d = 1'b0;
					qry_d = 1'b0;
					unique case (req.cmd)
						CMD_LOAD: begin
							cm_wr.addr = req.cell_index;
							cm_wr.open_we = 1'b1;
							cm_wr.open_wd = req.cell_open;
							state_d = S_RESP;
						end
						CMD_BEGIN: begin
							clr_d = '0;
							rem_d = start_q;
							state_d = S_CLEAR;
						end
						CMD_STEP: begin
							if (count_q == '0 || goal_flag_q || stuck_q) begin
								state_d = S_RESP;
							end else begin
								cm_re = 1'b1;
								cm_raddr = nb_acc.addr;
								nb_d = nb_acc;
								inb_d = nb_acc.inb;
								state_d = S_STEP_CHK;
							end
						end
						CMD_QUERY: begin
							cm_re = 1'b1;
							qry_d = 1'b1;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_CLEAR: begin
				cm_wr.addr = clr_q;
				cm_wr.used_we = 1'b1;
				cm_wr.trav_we = 1'b1;
				clr_d = clr_q + 1'b1;
				if ({1'b0, rem_q} >= GW) begin
					rem_d = CELL_W'({1'b0, rem_q} - GW);
				end
				if (&clr_q) begin
					clr_init_d = 1'b0;
					state_d = clr_init_q ? S_IDLE : S_BEGIN_SET;
				end
			end
			S_BEGIN_SET: begin
				cm_wr.addr = start_q;
				cm_wr.used_we = 1'b1;
				cm_wr.used_wd = 1'b1;
				sk_we = 1'b1;
				sk_waddr = '0;
				sk_wd = {start_q, rem_q[COL_W-1:0]};
				count_d = CNT_W'(1);
				walker_d = start_q;
				col_d = rem_q[COL_W-1:0];
				stuck_d = 1'b0;
				goal_flag_d = (start_q == goal_q);
				state_d = S_RESP;
			end
			S_STEP_CHK: begin
				if (free_now) begin
					state_d = S_MOVE;
				end else begin
					scan_d = '0;
					free_any_d = 1'b0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!scan_q[2]) begin
					cm_re = 1'b1;
					cm_raddr = nb_scan.addr;
					inb_d = nb_scan.inb;
					scan_d = scan_q + 1'b1;
					if (scan_q != '0) begin
						free_any_d = free_any_q | free_now;
					end
				end else begin
					state_d = (free_any_q | free_now) ? S_RESP : S_POP;
				end
			end
			S_MOVE: begin
				cm_wr.addr = nb_q.addr;
				cm_wr.used_we = 1'b1;
				cm_wr.used_wd = 1'b1;
				if (!count_q[CELL_W]) begin
					sk_we = 1'b1;
					count_d = count_q + 1'b1;
				end
				walker_d = nb_q.addr;
				col_d = nb_q.col;
				goal_flag_d = (nb_q.addr == goal_q);
				moved_d = 1'b1;
				state_d = S_RESP;
			end
			S_POP: begin
				cm_wr.addr = walker_q;
				cm_wr.trav_we = 1'b1;
				cm_wr.trav_wd = 1'b1;
				count_d = count_q - 1'b1;
				back_d = 1'b1;
				if (count_q == CNT_W'(1)) begin
					stuck_d = 1'b1;
					state_d = S_RESP;
				end else begin
					sk_re = 1'b1;
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				walker_d = sk_rd[SK_W-1 -: CELL_W];
				col_d = sk_rd[COL_W-1:0];
				goal_flag_d = (sk_rd[SK_W-1 -: CELL_W] == goal_q);
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d.position = walker_q;
					rsp_d.moved = moved_q;
					rsp_d.backtracked = back_q;
					rsp_d.at_goal = goal_flag_q;
					rsp_d.no_path = stuck_q;
					rsp_d.cell_used = qry_q & cm_rd.used;
					rsp_d.cell_travelled = qry_q & cm_rd.trav;
					rsp_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			clr_init_q <= 1'b1;
			count_q <= '0;
			walker_q <= '0;
			goal_flag_q <= 1'b0;
			stuck_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			scan_q <= '0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			clr_init_q <= clr_init_d;
			count_q <= count_d;
			walker_q <= walker_d;
			goal_flag_q <= goal_flag_d;
			stuck_q <= stuck_d;
			rsp_valid_q <= rsp_valid_d;
			scan_q <= scan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			goal_q <= CELL_W'(MAP_DEPTH - 1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_GOAL:  goal_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		col_q <= col_d;
		rem_q <= rem_d;
		nb_q <= nb_d;
		inb_s1 <= inb_d;
		free_any_q <= free_any_d;
		moved_q <= moved_d;
		back_q <= back_d;
		qry_q <= qry_d;
		rsp_q <= rsp_d;
	end

	a_stuck_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stuck_q |-> count_q == '0)
		else $error("Walker is stuck while the path stack still holds cells.");

	a_move_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |-> nb_q.inb)
		else $error("Walker moves to a cell outside the grid.");

	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.moved && rsp_q.backtracked))
		else $error("Result reports both a move and a backtrack.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAP_DEPTH))
		else $error("Path stack count exceeds the stack depth.");

endmodule

// File: sv/rdmw_cell_mem.sv
// Cell memory holding the open, used and travelled bits of every grid cell.
module rdmw_cell_mem import rdmw_pkg::*; (
	input  logic              clk,
	input  cell_wr_t          wr,
	input  logic              re,
	input  logic [CELL_W-1:0] raddr,
	output cell_bits_t        rd
);

	logic open_mem [MAP_DEPTH];
	logic used_mem [MAP_DEPTH];
	logic trav_mem [MAP_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.open_we) begin
			open_mem[wr.addr] <= wr.open_wd;
		end
		if (wr.used_we) begin
			used_mem[wr.addr] <= wr.used_wd;
		end
		if (wr.trav_we) begin
			trav_mem[wr.addr] <= wr.trav_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd <= '{open: open_mem[raddr], used: used_mem[raddr], trav: trav_mem[raddr]};
		end
	end

endmodule

// File: sv/rdmw_stack_mem.sv
// Path stack memory holding the cell index and column of every pushed cell.
module rdmw_stack_mem import rdmw_pkg::*; #(
	parameter int DATA_W = CELL_W + $clog2(GRID_WIDTH_DEF)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [CELL_W-1:0] waddr,
	input  logic [DATA_W-1:0] wd,
	input  logic              re,
	input  logic [CELL_W-1:0] raddr,
	output logic [DATA_W-1:0] rd
);

	logic [DATA_W-1:0] mem [MAP_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd <= mem[raddr];
		end
	end

endmodule

// File: verif/random_dfs_maze_walker_check.sv
`timescale 1ns / 100ps
// Checker for the maze walker: mirrors the walk state and compares every result beat.
module maze_walk_checker import rdmw_pkg::*; #(
	parameter int GRID_WIDTH = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CELL_W-1:0] cfg_data,
	input  logic              req_valid,
	input  logic              req_ready,
	input  req_t              req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  rsp_t              rsp,
	output int                mismatches,
	output int                outstanding,
	output int                moves,
	output int                retreats,
	output int                dead_walks
);

	localparam int CELLS = (GRID_WIDTH * GRID_HEIGHT < MAP_DEPTH) ?
		GRID_WIDTH * GRID_HEIGHT : MAP_DEPTH;

	bit                open_m [MAP_DEPTH];
	bit                used_m [MAP_DEPTH];
	bit                trav_m [MAP_DEPTH];
	logic [CELL_W-1:0] trail [MAP_DEPTH];
	int                trail_len;
	logic [CELL_W-1:0] walker;
	logic [CELL_W-1:0] start_reg;
	logic [CELL_W-1:0] goal_reg;
	bit                goal_hit;
	bit                stuck;
	rsp_t              predicted_rsp [$];
	rsp_t              want;

	function automatic bit neighbour_of(input logic [CELL_W-1:0] cur, input logic [1:0] dir,
			output logic [CELL_W-1:0] nb);
		int c;
		int n;
		c = int'(cur);
		case (dir)
			DIR_UP: begin
				if (c < GRID_WIDTH)
					return 1'b0;
				n = c - GRID_WIDTH;
			end
			DIR_DOWN: n = c + GRID_WIDTH;
			DIR_RIGHT: begin
				if (c % GRID_WIDTH == GRID_WIDTH - 1)
					return 1'b0;
				n = c + 1;
			end
			default: begin
				if (c % GRID_WIDTH == 0)
					return 1'b0;
				n = c - 1;
			end
		endcase
		nb = n[CELL_W-1:0];
		return n < CELLS;
	endfunction

	function automatic bit blocked_dir(input logic [CELL_W-1:0] cur, input logic [1:0] dir,
			output logic [CELL_W-1:0] nb);
		if (!neighbour_of(cur, dir, nb))
			return 1'b1;
		return !open_m[nb] || used_m[nb];
	endfunction

	function automatic rsp_t walk_step(input req_t r);
		rsp_t              o;
		logic [CELL_W-1:0] nb;
		logic [CELL_W-1:0] tmp;
		bit                dead_end;
		o = '0;
		case (r.cmd)
			CMD_LOAD: open_m[r.cell_index] = r.cell_open;
			CMD_BEGIN: begin
				for (int i = 0; i < MAP_DEPTH; i++) begin
					used_m[i] = 1'b0;
					trav_m[i] = 1'b0;
				end
				walker = start_reg;
				used_m[walker] = 1'b1;
				trail[0] = walker;
				trail_len = 1;
				stuck = 1'b0;
				goal_hit = (walker == goal_reg);
			end
			CMD_STEP: begin
				if (trail_len > 0 && !goal_hit && !stuck) begin
					if (!blocked_dir(walker, r.direction, nb)) begin
						walker = nb;
						used_m[nb] = 1'b1;
						if (trail_len < MAP_DEPTH) begin
							trail[trail_len] = nb;
							trail_len++;
						end
						o.moved = 1'b1;
						goal_hit = (walker == goal_reg);
						moves++;
					end else begin
						dead_end = 1'b1;
						for (int d = 0; d < 4; d++)
							if (!blocked_dir(walker, d[1:0], tmp))
								dead_end = 1'b0;
						if (dead_end) begin
							trav_m[walker] = 1'b1;
							trail_len--;
							o.backtracked = 1'b1;
							retreats++;
							if (trail_len == 0) begin
								stuck = 1'b1;
								dead_walks++;
							end else begin
								walker = trail[trail_len - 1];
								goal_hit = (walker == goal_reg);
							end
						end
					end
				end
			end
			default: begin
				o.cell_used = used_m[r.cell_index];
				o.cell_travelled = trav_m[r.cell_index];
			end
		endcase
		o.position = walker;
		o.at_goal = goal_hit;
		o.no_path = stuck;
		return o;
	endfunction

	task automatic compare_field(input string name, input logic [CELL_W-1:0] exp_v,
			input logic [CELL_W-1:0] got_v);
		if (exp_v !== got_v) begin
			if (mismatches < 10)
				$display("result mismatch in %s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_DEPTH; i++) begin
				used_m[i] = 1'b0;
				trav_m[i] = 1'b0;
			end
			trail_len = 0;
			walker = '0;
			start_reg = '0;
			goal_reg = '1;
			goal_hit = 1'b0;
			stuck = 1'b0;
			predicted_rsp.delete();
			mismatches = 0;
			outstanding = 0;
			moves = 0;
			retreats = 0;
			dead_walks = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_START)
					start_reg = cfg_data;
				else
					goal_reg = cfg_data;
			end
			if (rsp_valid && rsp_ready) begin
				if (predicted_rsp.size() == 0) begin
					if (mismatches < 10)
						$display("result beat with nothing awaited, position %0d", rsp.position);
					mismatches++;
				end else begin
					want = predicted_rsp.pop_front();
					compare_field("position", want.position, rsp.position);
					compare_field("moved", CELL_W'(want.moved), CELL_W'(rsp.moved));
					compare_field("backtracked", CELL_W'(want.backtracked),
						CELL_W'(rsp.backtracked));
					compare_field("at_goal", CELL_W'(want.at_goal), CELL_W'(rsp.at_goal));
					compare_field("no_path", CELL_W'(want.no_path), CELL_W'(rsp.no_path));
					compare_field("cell_used", CELL_W'(want.cell_used), CELL_W'(rsp.cell_used));
					compare_field("cell_travelled", CELL_W'(want.cell_travelled),
						CELL_W'(rsp.cell_travelled));
				end
			end
			if (req_valid && req_ready)
				predicted_rsp.push_back(walk_step(req));
			outstanding = predicted_rsp.size();
		end
	end

endmodule

// File: verif/random_dfs_maze_walker_test.sv
`timescale 1ns / 100ps
// Testbench top for the maze walker: drives commands, register writes and result stalls.
module random_dfs_maze_walker_test;
	import rdmw_pkg::*;

	localparam int GRID_WIDTH = 32;
	localparam int GRID_HEIGHT = 32;
	localparam int TARGET_BEATS = 1800;
	localparam int SQUEEZE_AFTER = 1400;
	localparam int HOLD_CYCLES = 300;
	localparam longint TIMEOUT_NS = 64'd30_000_000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CELL_W-1:0] cfg_data;
	logic              req_valid;
	logic              req_ready;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_t              rsp;

	int mismatches;
	int outstanding;
	int moves;
	int retreats;
	int dead_walks;
	int beats_sent;
	int walks;
	bit maze [MAP_DEPTH];
	bit send_calm;
	bit squeeze;

	random_dfs_maze_walker #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	maze_walk_checker #(
		.GRID_WIDTH(GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) walk_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.moves(moves),
		.retreats(retreats),
		.dead_walks(dead_walks)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap(input bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	task automatic command(input cmd_t c, input logic [CELL_W-1:0] idx, input logic opn,
			input logic [1:0] dir);
		int   gap;
		req_t r;
		gap = pick_gap(send_calm);
		r.cmd = c;
		r.cell_index = idx;
		r.cell_open = opn;
		r.direction = dir;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		beats_sent++;
		if (c == CMD_LOAD)
			maze[idx] = opn;
		if (c == CMD_BEGIN)
			walks++;
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CELL_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [CELL_W-1:0] start, input logic [CELL_W-1:0] goal);
		settle();
		write_reg(REG_START, start);
		write_reg(REG_GOAL, goal);
	endtask

	initial begin : receiver
		int gap;
		int count;
		bit calm;
		rsp_ready = 1'b0;
		count = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = squeeze ? HOLD_CYCLES : pick_gap(calm);
			squeeze = 1'b0;
			@(negedge clk);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
			count++;
			if (count % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int                n;
		int                roll;
		int                tries;
		bit                squeezed;
		logic [CELL_W-1:0] s;
		logic [CELL_W-1:0] g;
		logic [CELL_W-1:0] off;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		send_calm = 1'b0;
		squeeze = 1'b0;
		squeezed = 1'b0;
		beats_sent = 0;
		walks = 0;
		s = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Before any walk: queries of a clean map and steps of an idle walker.
		command(CMD_QUERY, 10'd0, $urandom, $urandom);
		command(CMD_QUERY, 10'd1023, $urandom, $urandom);
		command(CMD_STEP, $urandom, $urandom, DIR_UP);
		command(CMD_STEP, $urandom, $urandom, DIR_DOWN);
		command(CMD_STEP, $urandom, $urandom, DIR_RIGHT);
		command(CMD_STEP, $urandom, $urandom, DIR_LEFT);
		command(CMD_LOAD, 10'd0, 1'b1, $urandom);
		command(CMD_LOAD, 10'd1023, 1'b0, $urandom);
		command(CMD_BEGIN, $urandom, $urandom, $urandom);
		command(CMD_QUERY, 10'd0, $urandom, $urandom);

		for (int i = 0; i < MAP_DEPTH; i++)
			command(CMD_LOAD, i[CELL_W-1:0], $urandom_range(0, 99) < 55, $urandom);

		// Walled-in corner: the only retreat empties the path.
		configure(10'd0, 10'd1023);
		command(CMD_LOAD, 10'd1, 1'b0, $urandom);
		command(CMD_LOAD, 10'd32, 1'b0, $urandom);
		command(CMD_BEGIN, $urandom, $urandom, $urandom);
		command(CMD_STEP, $urandom, $urandom, DIR_UP);
		command(CMD_STEP, $urandom, $urandom, DIR_LEFT);
		command(CMD_QUERY, 10'd0, $urandom, $urandom);

		// The cell past the right edge is open but must not count as a neighbor.
		configure(10'd31, 10'd1023);
		command(CMD_LOAD, 10'd32, 1'b1, $urandom);
		command(CMD_LOAD, 10'd30, 1'b0, $urandom);
		command(CMD_LOAD, 10'd63, 1'b0, $urandom);
		command(CMD_BEGIN, $urandom, $urandom, $urandom);
		command(CMD_STEP, $urandom, $urandom, DIR_RIGHT);

		// Reaching the goal freezes the walker, even after the goal moves.
		configure(10'd1023, 10'd1022);
		command(CMD_LOAD, 10'd1022, 1'b1, $urandom);
		command(CMD_BEGIN, $urandom, $urandom, $urandom);
		command(CMD_STEP, $urandom, $urandom, DIR_DOWN);
		command(CMD_STEP, $urandom, $urandom, DIR_LEFT);
		command(CMD_STEP, $urandom, $urandom, DIR_UP);
		settle();
		write_reg(REG_GOAL, 10'd0);
		command(CMD_STEP, $urandom, $urandom, DIR_RIGHT);
		command(CMD_QUERY, 10'd1022, $urandom, $urandom);

		configure(10'd0, 10'd0);
		command(CMD_BEGIN, $urandom, $urandom, $urandom);
		command(CMD_STEP, $urandom, $urandom, DIR_DOWN);

		while (beats_sent < TARGET_BEATS) begin
			send_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1) == 1) begin
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					s = 10'd0;
				end else if (roll < 10) begin
					s = 10'd1023;
				end else begin
					s = $urandom;
					tries = 0;
					while (!maze[s] && tries < 16) begin
						s = $urandom;
						tries++;
					end
				end
				roll = $urandom_range(0, 99);
				off = $urandom_range(0, 6);
				if (roll < 40)
					g = s + off - 10'd3;
				else if (roll < 50)
					g = s;
				else if (roll < 60)
					g = ($urandom_range(0, 1) == 1) ? 10'd1023 : 10'd0;
				else
					g = $urandom;
				configure(s, g);
			end
			command(CMD_BEGIN, $urandom, $urandom, $urandom);
			n = $urandom_range(10, 60);
			if (!squeezed && beats_sent >= SQUEEZE_AFTER) begin
				squeezed = 1'b1;
				squeeze = 1'b1;
				n = 60;
			end
			repeat (n) begin
				roll = $urandom_range(0, 99);
				off = $urandom_range(0, 70);
				if (roll < 80)
					command(CMD_STEP, $urandom, $urandom, $urandom);
				else if (roll < 88)
					command(CMD_QUERY, s + off - 10'd35, $urandom, $urandom);
				else if (roll < 95)
					command(CMD_LOAD, $urandom, $urandom_range(0, 99) < 55, $urandom);
				else
					command(CMD_BEGIN, $urandom, $urandom, $urandom);
			end
		end

		settle();
		repeat (20) @(negedge clk);
		$display("run covered %0d command beats over %0d walks: %0d cells entered, %0d retreats",
			beats_sent, walks, moves, retreats);
		$display("%0d walks ran out of path; one long result stall; %0d result checks failed",
			dead_walks, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
